[hdl/crar_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// crar_pkg
// Shared widths, codes and defaults for the counter rate averager.
// ----------------------------------------------------------------------------
package crar_pkg;

    // field widths of the channel words, the counters and the config register
    localparam int OP_W    = 1;
    localparam int IDX_W   = 4;
    localparam int AMT_W   = 16;
    localparam int TIME_W  = 32;
    localparam int RATE_W  = 64;
    localparam int COUNT_W = 48;
    localparam int CFG_W   = 16;

    // operation codes
    localparam logic [OP_W-1:0] OP_COUNT = 1'b0;
    localparam logic [OP_W-1:0] OP_TICK  = 1'b1;

    // defaults for the top level parameters and the interval register
    localparam int NUM_RATE_COUNTERS_DEF = 16;
    localparam int FRACTION_BITS_DEF     = 16;
    localparam logic [CFG_W-1:0] INTERVAL_RESET = 16'd5;

endpackage : crar_pkg
`default_nettype wire

[hdl/crar_in_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// crar_in_if
// Input channel: count events and statistics ticks, valid/ready handshake.
// ----------------------------------------------------------------------------
interface crar_in_if;

    logic                         valid;
    logic                         ready;
    logic [crar_pkg::OP_W-1:0]    operation;
    logic [crar_pkg::IDX_W-1:0]   counter_index;
    logic [crar_pkg::AMT_W-1:0]   add_amount;
    logic [crar_pkg::TIME_W-1:0]  now_seconds;

    modport source (
        output valid, operation, counter_index, add_amount, now_seconds,
        input  ready
    );

    modport sink (
        input  valid, operation, counter_index, add_amount, now_seconds,
        output ready
    );

endinterface : crar_in_if
`default_nettype wire

[hdl/crar_out_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// crar_out_if
// Output channel: one smoothed rate word per counter, valid/ready handshake.
// ----------------------------------------------------------------------------
interface crar_out_if;

    logic                         valid;
    logic                         ready;
    logic [crar_pkg::IDX_W-1:0]   counter_index_out;
    logic [crar_pkg::RATE_W-1:0]  rate;
    logic                         last_of_run;

    modport source (
        output valid, counter_index_out, rate, last_of_run,
        input  ready
    );

    modport sink (
        input  valid, counter_index_out, rate, last_of_run,
        output ready
    );

endinterface : crar_out_if
`default_nettype wire

[hdl/crar_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// crar_div
// Restoring divider, one quotient bit per cycle, truncating. The dividend is
// shifted out of the quotient register as the quotient bits shift in.
// ----------------------------------------------------------------------------
module crar_div #(
    parameter int DIVIDEND_W = crar_pkg::COUNT_W + crar_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [DIVIDEND_W-1:0]         i_dividend,
    input  wire logic [crar_pkg::TIME_W-1:0]   i_divisor,
    output logic                               o_done,
    output logic [DIVIDEND_W-1:0]              o_quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);
    localparam int REM_W = crar_pkg::TIME_W + 1;

    logic                        r_busy;
    logic                        r_done;
    logic [CNT_W-1:0]            r_cnt;
    logic [REM_W-1:0]            r_rem;
    logic [DIVIDEND_W-1:0]       r_quo;
    logic [crar_pkg::TIME_W-1:0] r_div;

    logic [REM_W-1:0] rem_shift;
    logic [REM_W-1:0] rem_diff;
    logic             fits;

    // shift in the next dividend bit and trial-subtract the divisor
    always_comb begin
        rem_shift = {r_rem[REM_W-2:0], r_quo[DIVIDEND_W-1]};
        rem_diff  = rem_shift - {1'b0, r_div};
        fits      = (rem_shift >= {1'b0, r_div});
    end

    // control: count the steps, flag the end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIVIDEND_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // datapath: remainder and quotient
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? rem_diff : rem_shift;
            r_quo <= {r_quo[DIVIDEND_W-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule : crar_div
`default_nettype wire

[hdl/counter_rate_averager.sv]
`default_nettype none
// Count event: after acceptance, decode, row read and row write; no result.
// Statistics tick with no update: decode only; no result.
// Update tick: per counter a row read, a bit-serial divide in the shared
// divider, a two-step blend and an emit that waits for a free output
// register; no new input is taken until the whole run has ended.
// Reset (synchronous, active low) clears all counter rows at once via row
// valid bits; the block leaves reset idle and ready.
// ----------------------------------------------------------------------------
// counter_rate_averager
// Bank of event counters with smoothed per-counter rates, updated on
// statistics ticks through one shared serial divider under a sequencer.
// ----------------------------------------------------------------------------
module counter_rate_averager #(
    parameter int NUM_RATE_COUNTERS = crar_pkg::NUM_RATE_COUNTERS_DEF,
    parameter int FRACTION_BITS     = crar_pkg::FRACTION_BITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [crar_pkg::CFG_W-1:0]  i_cfg_wdata,
    crar_in_if.sink                          i_in,
    crar_out_if.source                       o_out
);

    localparam int AW     = (NUM_RATE_COUNTERS > 1) ? $clog2(NUM_RATE_COUNTERS) : 1;
    localparam int EXT_W  = (AW > crar_pkg::IDX_W) ? AW : crar_pkg::IDX_W;
    localparam int DIV_W  = crar_pkg::COUNT_W + FRACTION_BITS;
    localparam int CW     = crar_pkg::COUNT_W;
    localparam int RW     = crar_pkg::RATE_W;
    localparam int TW     = crar_pkg::TIME_W;

    typedef struct packed {
        logic [CW-1:0] evt;
        logic [CW-1:0] snap;
        logic [RW-1:0] rate;
    } t_row;

    typedef enum logic [10:0] {
        S_IDLE    = 11'b000_0000_0001,
        S_DECODE  = 11'b000_0000_0010,
        S_CNT_RD  = 11'b000_0000_0100,
        S_CNT_WR  = 11'b000_0000_1000,
        S_RD      = 11'b000_0001_0000,
        S_RD_WAIT = 11'b000_0010_0000,
        S_DIV     = 11'b000_0100_0000,
        S_BLEND1  = 11'b000_1000_0000,
        S_BLEND2  = 11'b001_0000_0000,
        S_EMIT    = 11'b010_0000_0000,
        S_SPARE   = 11'b100_0000_0000
    } t_state;

    t_state                       r_state;
    logic                         r_started;
    logic [TW-1:0]                r_last_time;
    logic [TW-1:0]                r_elapsed;
    logic [crar_pkg::CFG_W-1:0]   r_interval;
    logic [NUM_RATE_COUNTERS-1:0] r_valid;
    logic [AW-1:0]                r_ctr;

    // latched input word
    logic [crar_pkg::OP_W-1:0]    r_op;
    logic [crar_pkg::IDX_W-1:0]   r_idx;
    logic [crar_pkg::AMT_W-1:0]   r_amt;
    logic [TW-1:0]                r_now;

    // row store
    t_row                         r_mem [NUM_RATE_COUNTERS];
    t_row                         r_rd_row;
    logic                         r_rd_valid;
    logic [RW-1:0]                r_acc;

    // output register
    logic                         r_out_valid;
    logic [crar_pkg::IDX_W-1:0]   r_out_idx;
    logic [RW-1:0]                r_out_rate;
    logic                         r_out_last;

    logic                         in_take;
    logic                         out_free;
    logic [EXT_W-1:0]             idx_ext;
    logic [EXT_W-1:0]             ctr_ext;
    logic                         idx_in_range;
    logic [TW-1:0]                elapsed;
    logic [TW-1:0]                limit;
    logic                         last_ctr;
    logic                         rd_en;
    logic [AW-1:0]                rd_addr;
    logic                         wr_en;
    logic [AW-1:0]                wr_addr;
    t_row                         wr_row;
    t_row                         cur;
    logic [CW-1:0]                delta;
    logic                         div_start;
    logic                         div_done;
    logic [DIV_W-1:0]             div_quo;
    logic [RW-1:0]                fresh;
    logic [3:0]                   corr;
    logic [RW-1:0]                blended;

    assign in_take  = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;

    // decode the latched word
    always_comb begin
        idx_ext      = EXT_W'(r_idx);
        ctr_ext      = EXT_W'(r_ctr);
        idx_in_range = (32'(r_idx) < NUM_RATE_COUNTERS);
        elapsed      = r_now - r_last_time;
        limit        = (r_interval == '0) ? TW'(1) : TW'(r_interval);
        last_ctr     = (r_ctr == AW'(NUM_RATE_COUNTERS - 1));
    end

    // row read data, an invalid row reads as zero
    always_comb begin
        cur   = r_rd_valid ? r_rd_row : '0;
        delta = cur.evt - cur.snap;
    end

    // blend: old*3/4 + new/4, truncated once, with the low bits carried separately
    always_comb begin
        fresh   = RW'(div_quo);
        corr    = ({2'b00, cur.rate[1:0]} + {1'b0, cur.rate[1:0], 1'b0}
                   + {2'b00, fresh[1:0]}) >> 2;
        blended = r_acc + {2'b00, fresh[RW-1:2]} + RW'(corr);
    end

    // memory port control
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_ctr;
        wr_en   = 1'b0;
        wr_addr = r_ctr;
        wr_row  = cur;
        unique case (r_state)
            S_CNT_RD: begin
                rd_en   = 1'b1;
                rd_addr = idx_ext[AW-1:0];
            end
            S_CNT_WR: begin
                wr_en      = 1'b1;
                wr_addr    = idx_ext[AW-1:0];
                wr_row.evt = cur.evt + CW'(r_amt);
            end
            S_RD: begin
                rd_en = 1'b1;
            end
            S_EMIT: begin
                wr_en       = out_free;
                wr_row.snap = cur.evt;
                wr_row.rate = r_acc;
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    assign div_start = (r_state == S_RD_WAIT);

    crar_div #(
        .DIVIDEND_W (DIV_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (DIV_W'(delta) << FRACTION_BITS),
        .i_divisor  (r_elapsed),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // row store: write and registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_row;
        end
        if (rd_en) begin
            r_rd_row <= r_mem[rd_addr];
        end
    end

    // latch the accepted word
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_op  <= i_in.operation;
            r_idx <= i_in.counter_index;
            r_amt <= i_in.add_amount;
            r_now <= i_in.now_seconds;
        end
    end

    // blend accumulator: hold 3*(old/4), then the blended rate, or the new rate if old is zero
    always_ff @(posedge i_clk) begin
        if (r_state == S_BLEND1) begin
            r_acc <= {1'b0, cur.rate[RW-1:2], 1'b0} + {2'b00, cur.rate[RW-1:2]};
        end else if (r_state == S_BLEND2) begin
            r_acc <= (cur.rate == '0) ? fresh : blended;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_started   <= 1'b0;
            r_last_time <= '0;
            r_elapsed   <= '0;
            r_interval  <= crar_pkg::INTERVAL_RESET;
            r_valid     <= '0;
            r_ctr       <= '0;
            r_rd_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_interval <= i_cfg_wdata;
            end
            if (rd_en) begin
                r_rd_valid <= r_valid[rd_addr];
            end
            if (wr_en) begin
                r_valid[wr_addr] <= 1'b1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        r_state <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    if (r_op == crar_pkg::OP_COUNT) begin
                        r_state <= idx_in_range ? S_CNT_RD : S_IDLE;
                    end else if (!r_started) begin
                        // first tick: clear the bank and start the clock
                        r_valid     <= '0;
                        r_last_time <= r_now;
                        r_started   <= 1'b1;
                        r_state     <= S_IDLE;
                    end else if (elapsed < limit) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_last_time <= r_now;
                        r_elapsed   <= elapsed;
                        r_ctr       <= '0;
                        r_state     <= S_RD;
                    end
                end
                S_CNT_RD: begin
                    r_state <= S_CNT_WR;
                end
                S_CNT_WR: begin
                    r_state <= S_IDLE;
                end
                S_RD: begin
                    r_state <= S_RD_WAIT;
                end
                S_RD_WAIT: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_BLEND1;
                    end
                end
                S_BLEND1: begin
                    r_state <= S_BLEND2;
                end
                S_BLEND2: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        if (last_ctr) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_ctr   <= r_ctr + AW'(1);
                            r_state <= S_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // output register: load on emit, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_EMIT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT && out_free) begin
            r_out_idx  <= ctr_ext[crar_pkg::IDX_W-1:0];
            r_out_rate <= r_acc;
            r_out_last <= last_ctr;
        end
    end

    assign i_in.ready              = (r_state == S_IDLE);
    assign o_out.valid             = r_out_valid;
    assign o_out.counter_index_out = r_out_idx;
    assign o_out.rate              = r_out_rate;
    assign o_out.last_of_run       = r_out_last;

endmodule : counter_rate_averager
`default_nettype wire
